@@ hdl/w3l_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3l_pkg: shared types and constants
// Word formats, controller commands and weights for the weighted 3D life block.
// ----------------------------------------------------------------------------
package w3l_pkg;

	localparam int DEF_SIZE_X = 16;
	localparam int DEF_SIZE_Y = 16;
	localparam int DEF_SIZE_Z = 16;

	localparam int REG_W  = 13;
	localparam int POS_W  = 4;
	localparam int SUM_MAX = 4892;

	localparam logic [REG_W-1:0] WEIGHT_FACE   = 13'd256;
	localparam logic [REG_W-1:0] WEIGHT_EDGE   = 13'd181;
	localparam logic [REG_W-1:0] WEIGHT_CORNER = 13'd148;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_ADVANCE = 2'd3;

	localparam logic [1:0] CFG_SURVIVE_LOW  = 2'd0;
	localparam logic [1:0] CFG_SURVIVE_HIGH = 2'd1;
	localparam logic [1:0] CFG_BIRTH_LOW    = 2'd2;
	localparam logic [1:0] CFG_BIRTH_HIGH   = 2'd3;

	typedef struct packed {
		logic [1:0]       mode;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic             cell_in;
	} in_t;

	typedef struct packed {
		logic cell_out;
		logic is_read_data;
	} out_t;

	typedef struct packed {
		logic load;
		logic cell_step;
		logic clr_wr;
		logic nbr_step;
		logic eval;
		logic rd_issue;
		logic wr_do;
		logic done;
		logic swap;
	} cmd_t;

	typedef struct packed {
		logic cell_last;
		logic nbr_last;
	} sts_t;

	function automatic logic [REG_W-1:0] weight_of(input logic [1:0] d2);
		logic [REG_W-1:0] w;
		unique case (d2)
			2'd1:    w = WEIGHT_FACE;
			2'd2:    w = WEIGHT_EDGE;
			2'd3:    w = WEIGHT_CORNER;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ hdl/w3l_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3l_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module w3l_ram #(
	parameter int W     = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/w3l_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3l_ctrl: controller
// Sequences reset clearing, writes, reads, clears and generation sweeps.
// ----------------------------------------------------------------------------
module w3l_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	input  w3l_pkg::sts_t sts,
	output w3l_pkg::cmd_t cmd,
	output logic          busy
);
	import w3l_pkg::*;

	localparam logic [3:0] ST_RST  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CLR  = 4'd2;
	localparam logic [3:0] ST_WR   = 4'd3;
	localparam logic [3:0] ST_RD1  = 4'd4;
	localparam logic [3:0] ST_RD2  = 4'd5;
	localparam logic [3:0] ST_NBR  = 4'd6;
	localparam logic [3:0] ST_DRN  = 4'd7;
	localparam logic [3:0] ST_EVL  = 4'd8;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_RST: begin
				cmd.clr_wr = 1'b1;
				cmd.cell_step = 1'b1;
				if (sts.cell_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (mode)
						MODE_WRITE:   state_d = ST_WR;
						MODE_READ:    state_d = ST_RD1;
						MODE_CLEAR:   state_d = ST_CLR;
						MODE_ADVANCE: state_d = ST_NBR;
					endcase
				end
			end
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				cmd.cell_step = 1'b1;
				if (sts.cell_last) begin
					cmd.done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WR: begin
				cmd.wr_do = 1'b1;
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RD1: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			ST_NBR: begin
				cmd.nbr_step = 1'b1;
				if (sts.nbr_last) state_d = ST_DRN;
			end
			ST_DRN: begin
				state_d = ST_EVL;
			end
			ST_EVL: begin
				cmd.eval = 1'b1;
				cmd.cell_step = 1'b1;
				if (sts.cell_last) begin
					cmd.swap = 1'b1;
					cmd.done = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_NBR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RST;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.nbr_step, cmd.eval, cmd.rd_issue, cmd.wr_do}))
		else $error("more than one datapath action in a cycle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("word loaded while busy");
	a_swap_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap |-> (cmd.done && cmd.eval && sts.cell_last))
		else $error("plane swap outside the end of a sweep");
endmodule

@@ hdl/w3l_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3l_dp: datapath
// Two cell planes, scan counters, neighbor accumulator and rule evaluation.
// ----------------------------------------------------------------------------
module w3l_dp #(
	parameter int SIZE_X = w3l_pkg::DEF_SIZE_X,
	parameter int SIZE_Y = w3l_pkg::DEF_SIZE_Y,
	parameter int SIZE_Z = w3l_pkg::DEF_SIZE_Z
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  w3l_pkg::in_t             in_word,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [w3l_pkg::REG_W-1:0] cfg_data,
	input  w3l_pkg::cmd_t            cmd,
	output w3l_pkg::sts_t            sts,
	output logic                     out_valid,
	output w3l_pkg::out_t            out_word
);
	import w3l_pkg::*;

	localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW = $clog2(DEPTH);
	localparam int CX = $clog2(SIZE_X);
	localparam int CY = $clog2(SIZE_Y);
	localparam int CZ = $clog2(SIZE_Z);

	function automatic logic [AW-1:0] addr_of(input int ax, input int ay, input int az);
		int a;
		a = (ax * SIZE_Y + ay) * SIZE_Z + az;
		return a[AW-1:0];
	endfunction

	logic [REG_W-1:0] sl_q, sh_q, bl_q, bh_q;
	logic [CX-1:0] x_q;
	logic [CY-1:0] y_q;
	logic [CZ-1:0] z_q;
	logic [1:0] dx_q, dy_q, dz_q;
	logic [CX-1:0] px_q;
	logic [CY-1:0] py_q;
	logic [CZ-1:0] pz_q;
	logic inside_q, bit_q, rd_q, sel_q;
	logic [REG_W-1:0] acc_q, w_s1;
	logic acc_v_s1, self_s1, self_q;
	logic [AW-1:0] cell_addr, pos_addr, nbr_addr, raddr;
	logic inb, xl, yl, zl, nv, rdat, rdat0, rdat1;
	logic [1:0] d2;
	logic [REG_W-1:0] acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q <= 13'd1024;
			sh_q <= 13'd1280;
			bl_q <= 13'd1280;
			bh_q <= 13'd1280;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SURVIVE_LOW:  sl_q <= cfg_data;
				CFG_SURVIVE_HIGH: sh_q <= cfg_data;
				CFG_BIRTH_LOW:    bl_q <= cfg_data;
				CFG_BIRTH_HIGH:   bh_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= CX'(in_word.pos_x);
			py_q <= CY'(in_word.pos_y);
			pz_q <= CZ'(in_word.pos_z);
			inside_q <= (int'(in_word.pos_x) < SIZE_X) && (int'(in_word.pos_y) < SIZE_Y)
				&& (int'(in_word.pos_z) < SIZE_Z);
			bit_q <= in_word.cell_in;
			rd_q <= (in_word.mode == MODE_READ);
		end
	end

	assign xl = (x_q == CX'(SIZE_X - 1));
	assign yl = (y_q == CY'(SIZE_Y - 1));
	assign zl = (z_q == CZ'(SIZE_Z - 1));
	assign sts.cell_last = xl && yl && zl;
	assign sts.nbr_last = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			dz_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (cmd.cell_step) begin
				z_q <= zl ? '0 : z_q + 1'b1;
				if (zl) begin
					y_q <= yl ? '0 : y_q + 1'b1;
					if (yl) x_q <= xl ? '0 : x_q + 1'b1;
				end
			end
			if (cmd.nbr_step) begin
				dz_q <= (dz_q == 2'd2) ? 2'd0 : dz_q + 2'd1;
				if (dz_q == 2'd2) begin
					dy_q <= (dy_q == 2'd2) ? 2'd0 : dy_q + 2'd1;
					if (dy_q == 2'd2) dx_q <= (dx_q == 2'd2) ? 2'd0 : dx_q + 2'd1;
				end
			end
			if (cmd.swap) sel_q <= ~sel_q;
		end
	end

	assign cell_addr = addr_of(int'(x_q), int'(y_q), int'(z_q));
	assign pos_addr = addr_of(int'(px_q), int'(py_q), int'(pz_q));
	assign nbr_addr = addr_of(int'(x_q) + int'(dx_q) - 1, int'(y_q) + int'(dy_q) - 1,
		int'(z_q) + int'(dz_q) - 1);
	assign inb = ((x_q != '0) || (dx_q != 2'd0)) && (!xl || (dx_q != 2'd2))
		&& ((y_q != '0) || (dy_q != 2'd0)) && (!yl || (dy_q != 2'd2))
		&& ((z_q != '0) || (dz_q != 2'd0)) && (!zl || (dz_q != 2'd2));
	assign d2 = 2'(dx_q != 2'd1) + 2'(dy_q != 2'd1) + 2'(dz_q != 2'd1);
	assign raddr = cmd.rd_issue ? pos_addr : nbr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_v_s1 <= 1'b0;
			self_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			acc_v_s1 <= cmd.nbr_step && inb && (d2 != 2'd0);
			self_s1 <= cmd.nbr_step && (d2 == 2'd0);
			if (cmd.eval) begin
				acc_q <= '0;
			end else if (acc_v_s1 && rdat) begin
				acc_q <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= weight_of(d2);
		if (self_s1) self_q <= rdat;
	end

	assign acc_sum = acc_q + w_s1;
	assign nv = self_q ? ((acc_q >= sl_q) && (acc_q <= sh_q))
		: ((acc_q >= bl_q) && (acc_q <= bh_q));

	logic we0, we1, wd0, wd1;
	logic [AW-1:0] wa0, wa1;
	logic cur_we, cur_wd;
	logic [AW-1:0] cur_wa;

	assign cur_we = cmd.clr_wr || (cmd.wr_do && inside_q);
	assign cur_wa = cmd.clr_wr ? cell_addr : pos_addr;
	assign cur_wd = cmd.clr_wr ? 1'b0 : bit_q;
	assign we0 = sel_q ? cmd.eval : cur_we;
	assign wa0 = sel_q ? cell_addr : cur_wa;
	assign wd0 = sel_q ? nv : cur_wd;
	assign we1 = sel_q ? cur_we : cmd.eval;
	assign wa1 = sel_q ? cur_wa : cell_addr;
	assign wd1 = sel_q ? cur_wd : nv;
	assign rdat = sel_q ? rdat1 : rdat0;

	w3l_ram #(.W(1), .DEPTH(DEPTH)) u_plane0 (
		.clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(raddr), .rdata(rdat0)
	);
	w3l_ram #(.W(1), .DEPTH(DEPTH)) u_plane1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(raddr), .rdata(rdat1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			out_word.is_read_data <= rd_q;
			out_word.cell_out <= rd_q && inside_q && rdat;
		end
	end

	a_valid_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid)
		else $error("result strobe held for two cycles");
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= REG_W'(SUM_MAX))
		else $error("neighbor sum out of range");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |=> (acc_q == '0))
		else $error("accumulator not cleared after evaluation");
endmodule

@@ hdl/weighted_3d_life_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_3d_life_step: weighted 3D life engine
// The result strobe is registered from the last state of each command.
// An advance reads the 27 cells around each cell one by one from a single RAM
// read port, then passes a drain state and an evaluate state for each cell.
// After reset the grid is cleared with busy high; the receiver cannot stall
// and one item is in flight at a time.
// ----------------------------------------------------------------------------
module weighted_3d_life_step #(
	parameter int SIZE_X = w3l_pkg::DEF_SIZE_X,
	parameter int SIZE_Y = w3l_pkg::DEF_SIZE_Y,
	parameter int SIZE_Z = w3l_pkg::DEF_SIZE_Z
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  w3l_pkg::in_t              in_word,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [w3l_pkg::REG_W-1:0] cfg_data,
	output logic                      out_valid,
	output w3l_pkg::out_t             out_word
);
	import w3l_pkg::*;

	cmd_t cmd;
	sts_t sts;

	w3l_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(in_word.mode),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	w3l_dp #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_word(out_word)
	);
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for weighted_3d_life_step
// Drives cell writes, reads, clears and generation steps under several rule
// settings, predicts every result word from a model grid and checks it.
// ----------------------------------------------------------------------------
module testbench;
	import w3l_pkg::*;

	localparam int EDGE_N = 16;
	localparam int CELLS = EDGE_N * EDGE_N * EDGE_N;
	localparam int STALL_LIMIT = 400000;

	class life_scoreboard;
		bit          grid [CELLS];
		bit          next_grid [CELLS];
		logic [12:0] surv_lo, surv_hi, born_lo, born_hi;
		out_t        pending [$];
		int          errors;

		function new();
			foreach (grid[i]) grid[i] = 1'b0;
			surv_lo = 13'd1024;
			surv_hi = 13'd1280;
			born_lo = 13'd1280;
			born_hi = 13'd1280;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [12:0] val);
			case (idx)
				CFG_SURVIVE_LOW:  surv_lo = val;
				CFG_SURVIVE_HIGH: surv_hi = val;
				CFG_BIRTH_LOW:    born_lo = val;
				CFG_BIRTH_HIGH:   born_hi = val;
			endcase
		endfunction

		function int at(int x, int y, int z);
			return (x * EDGE_N + y) * EDGE_N + z;
		endfunction

		function logic [12:0] neighbor_sum(int x, int y, int z);
			logic [12:0] s;
			int ax, ay, az, d2;
			s = '0;
			for (int dx = -1; dx <= 1; dx++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dz = -1; dz <= 1; dz++) begin
						ax = x + dx;
						ay = y + dy;
						az = z + dz;
						d2 = dx * dx + dy * dy + dz * dz;
						if (d2 != 0 && ax >= 0 && ax < EDGE_N && ay >= 0 && ay < EDGE_N &&
							az >= 0 && az < EDGE_N && grid[at(ax, ay, az)])
							s += (d2 == 1) ? WEIGHT_FACE : (d2 == 2) ? WEIGHT_EDGE : WEIGHT_CORNER;
					end
			return s;
		endfunction

		function void step_generation();
			logic [12:0] s;
			for (int x = 0; x < EDGE_N; x++)
				for (int y = 0; y < EDGE_N; y++)
					for (int z = 0; z < EDGE_N; z++) begin
						s = neighbor_sum(x, y, z);
						if (grid[at(x, y, z)])
							next_grid[at(x, y, z)] = (s >= surv_lo && s <= surv_hi);
						else
							next_grid[at(x, y, z)] = (s >= born_lo && s <= born_hi);
					end
			grid = next_grid;
		endfunction

		function void note_input(in_t w);
			out_t r;
			r = '0;
			case (w.mode)
				MODE_WRITE:   grid[at(w.pos_x, w.pos_y, w.pos_z)] = w.cell_in;
				MODE_READ: begin
					r.cell_out = grid[at(w.pos_x, w.pos_y, w.pos_z)];
					r.is_read_data = 1'b1;
				end
				MODE_CLEAR:   foreach (grid[i]) grid[i] = 1'b0;
				MODE_ADVANCE: step_generation();
			endcase
			pending.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check(out_t got);
			out_t exp;
			if (pending.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			exp = pending.pop_front();
			if (got.cell_out !== exp.cell_out)
				report($sformatf("cell_out got %b expected %b", got.cell_out, exp.cell_out));
			if (got.is_read_data !== exp.is_read_data)
				report($sformatf("is_read_data got %b expected %b",
					got.is_read_data, exp.is_read_data));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_t               in_word;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [REG_W-1:0]  cfg_data;
	logic              out_valid;
	out_t              out_word;

	life_scoreboard sb;
	int stall_cycles;
	int sent, reads, advances, clears;

	weighted_3d_life_step dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid)
			sb.check(out_word);
	end

	always @(posedge clk) begin
		if ((start && !busy) || out_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task send_word(logic [1:0] m, int x, int y, int z, bit v, int gap);
		in_t w;
		w.mode = m;
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.pos_z = POS_W'(z);
		w.cell_in = v;
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_input(w);
		sent++;
		if (m == MODE_READ) reads++;
		if (m == MODE_ADVANCE) advances++;
		if (m == MODE_CLEAR) clears++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
	endtask

	task write_rules(logic [12:0] sl, logic [12:0] sh, logic [12:0] bl, logic [12:0] bh);
		logic [12:0] vals [4];
		vals = '{sl, sh, bl, bh};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(i[1:0], vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task random_phase(int count);
		int adv_at, gap, cx, cy, cz, x, y, z, pick;
		bit burst;
		logic [1:0] m;
		adv_at = $urandom_range(10, count - 5);
		cx = $urandom_range(1, 14);
		cy = $urandom_range(1, 14);
		cz = $urandom_range(1, 14);
		burst = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 10 == 0) burst = $urandom_range(0, 2) == 0;
			pick = $urandom_range(0, 99);
			if (i == adv_at) m = MODE_ADVANCE;
			else if (pick < 55) m = MODE_WRITE;
			else if (pick < 96) m = MODE_READ;
			else m = MODE_CLEAR;
			if ($urandom_range(0, 9) < 7) begin
				x = cx + $urandom_range(0, 2) - 1;
				y = cy + $urandom_range(0, 2) - 1;
				z = cz + $urandom_range(0, 2) - 1;
			end else begin
				x = $urandom_range(0, 15);
				y = $urandom_range(0, 15);
				z = $urandom_range(0, 15);
			end
			gap = burst ? 0 : $urandom_range(0, 8);
			send_word(m, x, y, z, $urandom_range(0, 3) != 0, gap);
		end
		drain_results();
	endtask

	initial begin
		sb = new();
		stall_cycles = 0;
		sent = 0;
		reads = 0;
		advances = 0;
		clears = 0;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_word(MODE_READ, 0, 0, 0, 1'b0, 0);
		send_word(MODE_WRITE, 0, 0, 0, 1'b1, 1);
		send_word(MODE_WRITE, 15, 15, 15, 1'b1, 0);
		send_word(MODE_READ, 15, 15, 15, 1'b0, 2);
		send_word(MODE_READ, 0, 0, 0, 1'b1, 0);
		send_word(MODE_WRITE, 0, 0, 0, 1'b0, 0);
		send_word(MODE_READ, 0, 0, 0, 1'b0, 3);
		send_word(MODE_CLEAR, 7, 7, 7, 1'b1, 0);
		send_word(MODE_READ, 15, 15, 15, 1'b0, 0);
		send_word(MODE_WRITE, 5, 5, 5, 1'b1, 0);
		send_word(MODE_WRITE, 5, 5, 6, 1'b1, 0);
		send_word(MODE_WRITE, 5, 6, 5, 1'b1, 0);
		send_word(MODE_WRITE, 6, 5, 5, 1'b1, 0);
		send_word(MODE_WRITE, 6, 6, 6, 1'b1, 0);
		send_word(MODE_WRITE, 0, 15, 0, 1'b1, 0);
		send_word(MODE_WRITE, 15, 0, 15, 1'b1, 4);
		send_word(MODE_ADVANCE, 10, 3, 9, 1'b0, 0);
		send_word(MODE_READ, 5, 5, 5, 1'b0, 0);
		send_word(MODE_READ, 6, 6, 5, 1'b0, 0);
		send_word(MODE_READ, 0, 15, 0, 1'b0, 8);
		send_word(MODE_READ, 5, 6, 6, 1'b0, 0);
		drain_results();

		write_rules(13'd0, 13'd8191, 13'd8191, 13'd0);
		random_phase(40);
		write_rules(13'($urandom_range(256, 900)), 13'($urandom_range(900, 1800)),
			13'($urandom_range(300, 1000)), 13'($urandom_range(1000, 1600)));
		random_phase(40);
		write_rules(13'd1500, 13'd1200, 13'd0, 13'd8191);
		random_phase(40);

		repeat (20) @(posedge clk);
		while (sb.pending.size() != 0) begin
			sb.report("expected result word never arrived");
			void'(sb.pending.pop_front());
		end
		$display("Covered %0d words: %0d reads, %0d generation steps, %0d clears,",
			sent, reads, advances, clears);
		$display("under four rule settings including full and empty ranges.");
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
